// File: sv/pbtd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the tail-drop packet buffer.
// No dependencies; used by the core.
package pbtd_pkg;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_e;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned BUF_SIZE_W = 11;
  localparam logic [BUF_SIZE_W-1:0] BUF_SIZE_RESET = 11'd1024;

  // Register index taken from paddr[2]; byte addresses are 4 * index.
  localparam logic REG_BUFFER_SIZE = 1'b0;

  localparam int unsigned ARRIVAL_W = 32;
  localparam int unsigned PROC_W = 16;
  localparam int unsigned START_W = 32;

endpackage

// File: sv/packet_buffer_tail_drop_core.sv
`timescale 1ns / 1ps
// Top level of the tail-drop packet buffer: APB register, pop/push sequencer.
// Depends on pbtd_pkg and pbtd_fifo_mem.
//
//   channel  | direction | handshake                 | beat payload
//   ---------+-----------+---------------------------+-------------------------------
//   in       | input     | in_valid_i / in_stall_o   | arrival_time_i, process_time_i
//   out      | output    | out_valid_o / out_stall_i | dropped_o, service_start_o
//   apb      | input     | psel/penable/pready       | paddr, pwdata, prdata
//
// A packet first pops the expired entries, those finishing by its arrival;
// the head memory read retires one entry per cycle.
// The result sits in an output register, so a new packet is taken while it waits.
// If that register is still occupied when the next decision is ready, the core
// holds in the pop state until it frees up. No clearing pass is needed after reset.
module packet_buffer_tail_drop_core #(
  parameter int unsigned QUEUE_DEPTH = 1024,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pbtd_pkg::ARRIVAL_W-1:0] arrival_time_i,
  input  logic [pbtd_pkg::PROC_W-1:0]    process_time_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          dropped_o,
  output logic [pbtd_pkg::START_W-1:0]   service_start_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pbtd_pkg::PADDR_W-1:0]   paddr,
  input  logic [pbtd_pkg::PDATA_W-1:0]   pwdata,
  output logic [pbtd_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W = ((TIME_WIDTH > pbtd_pkg::PROC_W) ? TIME_WIDTH
                                                                  : pbtd_pkg::PROC_W) + 1;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [31:0] DEPTH_32 = 32'(QUEUE_DEPTH);

  // Configuration register.
  logic [pbtd_pkg::BUF_SIZE_W-1:0] buf_size_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_size_q <= pbtd_pkg::BUF_SIZE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == pbtd_pkg::REG_BUFFER_SIZE)) begin
      buf_size_q <= pwdata[pbtd_pkg::BUF_SIZE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == pbtd_pkg::REG_BUFFER_SIZE) begin
      prdata = pbtd_pkg::PDATA_W'(buf_size_q);
    end
  end

  // Queue state.
  pbtd_pkg::state_e state_q, state_d;
  logic [PTR_W-1:0]      head_q, head_d;
  logic [PTR_W-1:0]      tail_q, tail_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [TIME_WIDTH-1:0] last_q, last_d;
  logic [TIME_WIDTH-1:0] arr_q, arr_d;
  logic [pbtd_pkg::PROC_W-1:0] ptime_q, ptime_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_drop_q, out_drop_d;
  logic [pbtd_pkg::START_W-1:0] out_start_q, out_start_d;

  // Memory interface.
  logic                  mem_we;
  logic [TIME_WIDTH-1:0] head_finish;

  // Datapath helpers.
  logic [63:0]           arr_ext;
  logic [63:0]           start_ext;
  logic [TIME_WIDTH-1:0] start_t;
  logic [SUM_W-1:0]      sum;
  logic [TIME_WIDTH-1:0] finish;
  logic [31:0]           cap32;
  logic                  full;
  logic                  pop;
  logic                  out_free;

  // Arrival as stored, widened back to the output width.
  function automatic logic [pbtd_pkg::START_W-1:0] arrival_time_from_q(
    input logic [TIME_WIDTH-1:0] arr
  );
    logic [63:0] ext;
    ext = 64'(arr);
    return ext[pbtd_pkg::START_W-1:0];
  endfunction

  assign arr_ext   = 64'(arrival_time_i);
  assign start_t   = (cnt_q == '0) ? arr_q : last_q;
  assign start_ext = 64'(start_t);
  assign sum       = SUM_W'(start_t) + SUM_W'(ptime_q);
  assign finish    = (sum[SUM_W-1:TIME_WIDTH] != '0) ? '1 : sum[TIME_WIDTH-1:0];
  assign cap32     = (32'(buf_size_q) > DEPTH_32) ? DEPTH_32 : 32'(buf_size_q);
  assign full      = 32'(cnt_q) >= cap32;
  assign pop       = (cnt_q != '0) && (head_finish <= arr_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign in_stall_o = (state_q != pbtd_pkg::ST_IDLE);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    arr_d       = arr_q;
    ptime_d     = ptime_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_drop_d  = out_drop_q;
    out_start_d = out_start_q;
    mem_we      = 1'b0;
    unique case (state_q)
      pbtd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          arr_d   = arr_ext[TIME_WIDTH-1:0];
          ptime_d = process_time_i;
          state_d = pbtd_pkg::ST_POP;
        end
      end
      pbtd_pkg::ST_POP: begin
        if (pop) begin
          // The memory reads the next head address, so pops run one per cycle.
          head_d = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
          cnt_d  = cnt_q - 1'b1;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_drop_d  = full;
          if (full) begin
            out_start_d = 32'(arrival_time_from_q(arr_q));
          end else begin
            out_start_d = start_ext[pbtd_pkg::START_W-1:0];
            mem_we      = 1'b1;
            last_d      = finish;
            tail_d      = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;
            cnt_d       = cnt_q + 1'b1;
          end
          state_d = pbtd_pkg::ST_IDLE;
        end
      end
      default: state_d = pbtd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pbtd_pkg::ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    arr_q       <= arr_d;
    ptime_q     <= ptime_d;
    out_drop_q  <= out_drop_d;
    out_start_q <= out_start_d;
  end

  pbtd_fifo_mem #(
    .DEPTH (QUEUE_DEPTH),
    .DATA_W(TIME_WIDTH),
    .ADDR_W(PTR_W)
  ) u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (mem_we),
    .waddr_i(tail_q),
    .wdata_i(finish),
    .raddr_i(head_d),
    .rdata_o(head_finish)
  );

  assign out_valid_o     = out_valid_q;
  assign dropped_o       = out_drop_q;
  assign service_start_o = out_start_q;

endmodule

// File: sv/pbtd_fifo_mem.sv
`timescale 1ns / 1ps
// Finish-time memory: one write port, one synchronous read port.
// A write to the address read in the same cycle is forwarded to the output.
module pbtd_fifo_mem #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned DATA_W = 32,
  parameter int unsigned ADDR_W = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q;
  logic [DATA_W-1:0] fwd_data_q;
  logic              fwd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q       <= mem[raddr_i];
    fwd_data_q <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : rd_q;

endmodule
